// ===== src/svv_pkg.sv =====
`timescale 1ns / 1ps

package svv_pkg;

  localparam int unsigned MAX_LEN = 64;
  localparam int unsigned CORE_COUNT = 3;

  localparam logic [1:0] SEC_CORE  = 2'd0;
  localparam logic [1:0] SEC_PRE   = 2'd1;
  localparam logic [1:0] SEC_BUILD = 2'd2;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [2:0] CORE_DONE_MAX  = 3'd7;
  localparam logic [1:0] ID_LEN_MANY    = 2'd2;
  localparam logic [6:0] BYTE_COUNT_MAX = 7'd127;

  typedef struct packed {
    logic [1:0] section;
    logic [2:0] core_done;
    logic [1:0] id_len;
    logic       first_zero;
    logic       all_digits;
    logic       failed;
    logic [6:0] byte_count;
  } svv_state_t;

  localparam svv_state_t SVV_RESET = '{
    section:    SEC_CORE,
    core_done:  3'd0,
    id_len:     2'd0,
    first_zero: 1'b0,
    all_digits: 1'b1,
    failed:     1'b0,
    byte_count: 7'd0
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= 8'h39);
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_MINUS);
  endfunction

  function automatic svv_state_t take_char(input svv_state_t s, input logic [7:0] c);
    svv_state_t r;
    r = s;
    if (s.id_len == 2'd0) r.first_zero = (c == CH_ZERO);
    if (!is_digit(c)) r.all_digits = 1'b0;
    if (s.id_len < ID_LEN_MANY) r.id_len = s.id_len + 2'd1;
    return r;
  endfunction

  function automatic svv_state_t end_piece(input svv_state_t s);
    svv_state_t r;
    r = s;
    if (s.id_len == 2'd0) r.failed = 1'b1;
    if ((s.section != SEC_BUILD) && s.all_digits && (s.id_len >= ID_LEN_MANY) &&
        s.first_zero) r.failed = 1'b1;
    if (s.section == SEC_CORE) begin
      if (!s.all_digits) r.failed = 1'b1;
      if (s.core_done < CORE_DONE_MAX) r.core_done = s.core_done + 3'd1;
    end
    r.id_len     = 2'd0;
    r.first_zero = 1'b0;
    r.all_digits = 1'b1;
    return r;
  endfunction

endpackage

// ===== src/svv_parse.sv =====
`timescale 1ns / 1ps

module svv_parse (
  input  svv_pkg::svv_state_t st,
  input  logic [7:0]          character,
  input  logic                last,
  output svv_pkg::svv_state_t st_nxt,
  output logic                verdict
);
  import svv_pkg::*;

  svv_state_t s_char;
  svv_state_t s_end;

  always_comb begin
    s_char = st;
    if (st.byte_count < BYTE_COUNT_MAX) s_char.byte_count = st.byte_count + 7'd1;
    if (st.section == SEC_CORE) begin
      if (is_digit(character)) begin
        s_char = take_char(s_char, character);
      end else if (character == CH_DOT) begin
        s_char = end_piece(s_char);
        if (s_char.core_done >= 3'(CORE_COUNT)) s_char.failed = 1'b1;
      end else if ((character == CH_MINUS) || (character == CH_PLUS)) begin
        s_char = end_piece(s_char);
        if (s_char.core_done != 3'(CORE_COUNT)) s_char.failed = 1'b1;
        s_char.section = (character == CH_MINUS) ? SEC_PRE : SEC_BUILD;
      end else begin
        s_char.failed = 1'b1;
      end
    end else begin
      if (is_ident(character)) begin
        s_char = take_char(s_char, character);
      end else if (character == CH_DOT) begin
        s_char = end_piece(s_char);
      end else if ((character == CH_PLUS) && (st.section == SEC_PRE)) begin
        s_char = end_piece(s_char);
        s_char.section = SEC_BUILD;
      end else begin
        s_char.failed = 1'b1;
      end
    end

    s_end = end_piece(s_char);
    if ((s_end.section == SEC_CORE) && (s_end.core_done != 3'(CORE_COUNT)))
      s_end.failed = 1'b1;
    if (s_end.byte_count > 7'(MAX_LEN)) s_end.failed = 1'b1;

    verdict = !s_end.failed;
    st_nxt  = last ? SVV_RESET : s_char;
  end

endmodule

// ===== src/semver_string_validator_core.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid, in_stall  | in_character[7:0], in_last
// out     | output    | out_valid, out_stall| out_valid_res
//
// One byte per cycle sustained while in_stall is low; a last byte is held in the input
// register, then its verdict is loaded into the result register.
// The per-byte check is a single combinational step between the two registers.
// Reset (rst_n low, synchronous) empties both registers and clears parse state.
// in_stall rises only when a last byte waits behind a stalled, full result register.
module semver_string_validator_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_character,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_valid_res
);
  import svv_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;
  svv_state_t state_r;
  svv_state_t state_nxt;
  logic       verdict;
  logic       out_valid_r;
  logic       out_res_r;
  logic       out_free;
  logic       s1_consume;
  logic       in_take;

  svv_parse u_parse (
    .st        (state_r),
    .character (s1_char_r),
    .last      (s1_last_r),
    .st_nxt    (state_nxt),
    .verdict   (verdict)
  );

  assign out_free   = !out_valid_r || !out_stall;
  assign s1_consume = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall   = s1_valid_r && !s1_consume;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      state_r     <= SVV_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
        s1_char_r  <= in_character;
        s1_last_r  <= in_last;
      end else if (s1_consume) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_consume) state_r <= state_nxt;
      if (s1_consume && s1_last_r) begin
        out_valid_r <= 1'b1;
        out_res_r   <= verdict;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = out_res_r;

  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_consume && s1_last_r) |=> (state_r == SVV_RESET))
    else $error("parse state not cleared after last byte");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(s1_valid_r && s1_last_r))
    else $error("result loaded without a last byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_res_r)))
    else $error("stalled result lost or changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_last_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

endmodule

// ===== tb/semver_string_validator_core_tb.sv =====
`timescale 1ns / 1ps

module semver_string_validator_core_tb;
  import svv_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD = 80;
  localparam int unsigned RANDOM_BYTES = 470;

  typedef enum int {RX_FLOW, RX_SPARSE, RX_HALF, RX_PERIODIC} rx_mode_t;

  typedef struct {
    logic [1:0] sec;
    logic [2:0] numbers;
    logic [1:0] piece_len;
    logic       lead_zero;
    logic       digits_only;
    logic       bad;
    logic [6:0] nbytes;
  } grammar_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_character = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_valid_res;

  grammar_t    gram;
  logic        verdicts_due[$];
  logic [7:0]  text[$];
  logic [7:0]  marks[4] = '{CH_DOT, CH_PLUS, CH_MINUS, CH_ZERO};
  logic [7:0]  strays[12] = '{8'h00, 8'hFF, 8'h20, 8'h2F, 8'h3A, 8'h40,
                              8'h5B, 8'h60, 8'h7B, 8'h5F, 8'h80, 8'h7F};
  int unsigned faults = 0;
  int unsigned cycles = 0;
  int unsigned sent_bytes = 0;
  int          burst_left = 0;
  bit          steady = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_count = 0;
  int          mode_left = 0;
  rx_mode_t    rx_mode = RX_FLOW;

  semver_string_validator_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_character  (in_character),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("semver_string_validator_core verification failed");
      $finish;
    end
  end

  function automatic bit is_dec(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= 8'h39);
  endfunction

  function automatic bit is_word_char(logic [7:0] c);
    return is_dec(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_MINUS);
  endfunction

  function automatic void clear_grammar();
    gram = '{sec: SEC_CORE, numbers: 3'd0, piece_len: 2'd0, lead_zero: 1'b0,
             digits_only: 1'b1, bad: 1'b0, nbytes: 7'd0};
  endfunction

  function automatic void absorb(logic [7:0] c);
    if (gram.piece_len == 2'd0) gram.lead_zero = (c == CH_ZERO);
    if (!is_dec(c)) gram.digits_only = 1'b0;
    if (gram.piece_len != ID_LEN_MANY) gram.piece_len = gram.piece_len + 2'd1;
  endfunction

  function automatic void close_piece();
    if (gram.piece_len == 2'd0) gram.bad = 1'b1;
    if ((gram.sec != SEC_BUILD) && gram.digits_only && (gram.piece_len == ID_LEN_MANY) &&
        gram.lead_zero) gram.bad = 1'b1;
    if (gram.sec == SEC_CORE) begin
      if (!gram.digits_only) gram.bad = 1'b1;
      if (gram.numbers != CORE_DONE_MAX) gram.numbers = gram.numbers + 3'd1;
    end
    gram.piece_len = 2'd0;
    gram.lead_zero = 1'b0;
    gram.digits_only = 1'b1;
  endfunction

  function automatic void predict_verdict(logic [7:0] c, logic last);
    if (gram.nbytes != BYTE_COUNT_MAX) gram.nbytes = gram.nbytes + 7'd1;
    if (gram.sec == SEC_CORE) begin
      if (is_dec(c)) begin
        absorb(c);
      end else if (c == CH_DOT) begin
        close_piece();
        if (gram.numbers >= CORE_COUNT) gram.bad = 1'b1;
      end else if ((c == CH_MINUS) || (c == CH_PLUS)) begin
        close_piece();
        if (gram.numbers != CORE_COUNT) gram.bad = 1'b1;
        gram.sec = (c == CH_MINUS) ? SEC_PRE : SEC_BUILD;
      end else begin
        gram.bad = 1'b1;
      end
    end else begin
      if (is_word_char(c)) begin
        absorb(c);
      end else if (c == CH_DOT) begin
        close_piece();
      end else if ((c == CH_PLUS) && (gram.sec == SEC_PRE)) begin
        close_piece();
        gram.sec = SEC_BUILD;
      end else begin
        gram.bad = 1'b1;
      end
    end
    if (last) begin
      close_piece();
      if ((gram.sec == SEC_CORE) && (gram.numbers != CORE_COUNT)) gram.bad = 1'b1;
      if (gram.nbytes > MAX_LEN) gram.bad = 1'b1;
      verdicts_due.push_back(!gram.bad);
      clear_grammar();
    end
  endfunction

  function automatic void note_fault(string what);
    faults++;
    if (faults <= 10) $display("cycle %0d: %s", cycles, what);
  endfunction

  always @(posedge clk) begin : check_verdict
    logic want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        note_fault($sformatf("verdict %0b with none expected", out_valid_res));
      end else begin
        want = verdicts_due.pop_front();
        if (out_valid_res !== want)
          note_fault($sformatf("valid_res expected %0b, got %0b", want, out_valid_res));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      out_stall <= 1'b1;
      hold_count++;
      if (hold_count >= LONG_HOLD) begin
        hold_req = 1'b0;
        hold_count = 0;
      end
    end else begin
      if (mode_left <= 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (rx_mode)
        RX_FLOW:   out_stall <= 1'b0;
        RX_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HALF:   out_stall <= ($urandom_range(0, 1) == 0);
        default:   out_stall <= ((mode_left % 5) < 2);
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic last);
    int gap;
    if (!steady && (burst_left <= 0)) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_character <= c;
    in_last <= last;
    do @(posedge clk); while (in_stall);
    sent_bytes++;
    predict_verdict(c, last);
  endtask

  task automatic send_text();
    foreach (text[i]) send_byte(text[i], i == (text.size() - 1));
  endtask

  function automatic void load(string s);
    text.delete();
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endfunction

  task automatic send_word(string s);
    load(s);
    send_text();
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_core_numbers();
    send_word("0.0.0");
    send_word("1.2.3");
    send_word("10.20.30");
    send_word("01.2.3");
    send_word("1.02.3");
    send_word("1.2.03");
    send_word("1.2");
    send_word("1..3");
    send_word(".1.2");
    send_word("7");
    drain();
  endtask

  task automatic test_prerelease();
    send_word("1.2.3-alpha.1");
    send_word("1.0.0-x.7.z.92");
    send_word("1.2.3-0");
    send_word("1.2.3-01");
    send_word("1.2.3-0a");
    send_word("1.2.3--");
    send_word("1.2.3-");
    send_word("1.2.3-a..b");
    send_word("1.2-3");
    drain();
  endtask

  task automatic test_build_part();
    send_word("1.2.3+001");
    send_word("1.2.3-rc.1+build.5");
    send_word("1.2.3-a+b-c.00");
    send_word("1.2.3+a+b");
    send_word("1.2.3-a+b+c");
    send_word("1.2.3+");
    send_word("1.2.3+a.");
    send_word("1.2+3");
    send_word("+");
    send_word("-");
    send_word(".");
    drain();
  endtask

  task automatic test_stray_bytes();
    foreach (strays[k]) begin
      text.delete();
      text.push_back(strays[k]);
      send_text();
      load("1.2.3-a");
      text.push_back(strays[k]);
      send_text();
      load("1.2.3+b");
      text.insert(6, strays[k]);
      send_text();
      load("1..3");
      text.insert(2, strays[k]);
      send_text();
    end
    drain();
  endtask

  task automatic test_extra_core();
    send_word("1.2.3.4");
    send_word("1.2.3.4.5.6.7.8.9.10.11");
    send_word("1.2.3.4.5.6.7.8-a");
    drain();
  endtask

  task automatic test_length_limit();
    int unsigned sizes[5] = '{MAX_LEN - 1, MAX_LEN, MAX_LEN + 1, 127, 140};
    foreach (sizes[k]) begin
      load("1.2.3-");
      while (text.size() < sizes[k]) text.push_back(8'h61);
      send_text();
    end
    drain();
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    send_word("1.2.3-");
    send_word("1.2.3");
    send_word("01.2.3");
    send_word("4.5.6");
    send_word("x");
    send_word("0.0.0");
    steady = 1'b0;
    drain();
  endtask

  task automatic test_long_hold();
    steady = 1'b1;
    hold_req = 1'b1;
    repeat (12) begin
      send_word("1.2.3");
      send_word("0");
    end
    steady = 1'b0;
    drain();
  endtask

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 6))
      0, 1:    return CH_ZERO + 8'($urandom_range(0, 9));
      2, 3:    return 8'h61 + 8'($urandom_range(0, 25));
      4, 5:    return 8'h41 + 8'($urandom_range(0, 25));
      default: return CH_MINUS;
    endcase
  endfunction

  function automatic void add_piece(bit numeric);
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++)
      text.push_back(numeric ? CH_ZERO + 8'($urandom_range(0, 9)) : word_char());
  endfunction

  function automatic void add_ident_list();
    int n;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      if (i != 0) text.push_back(CH_DOT);
      add_piece(1'($urandom_range(0, 1)));
    end
  endfunction

  function automatic void make_version();
    int parts;
    text.delete();
    parts = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 5) : CORE_COUNT;
    for (int i = 0; i < parts; i++) begin
      if (i != 0) text.push_back(CH_DOT);
      add_piece(1'b1);
    end
    if ($urandom_range(0, 9) < 4) begin
      text.push_back(CH_MINUS);
      add_ident_list();
    end
    if ($urandom_range(0, 9) < 3) begin
      text.push_back(CH_PLUS);
      add_ident_list();
    end
  endfunction

  function automatic void mutate();
    int at;
    at = $urandom_range(0, text.size() - 1);
    case ($urandom_range(0, 3))
      0:       text[at] = 8'($urandom_range(0, 255));
      1:       text.insert(at, 8'($urandom_range(0, 255)));
      2:       if (text.size() > 1) text.delete(at);
      default: text.insert(at, marks[$urandom_range(0, 3)]);
    endcase
  endfunction

  task automatic test_random_versions();
    int unsigned first;
    int unsigned kind;
    int unsigned target;
    first = sent_bytes;
    while ((sent_bytes - first) < RANDOM_BYTES) begin
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
        text.delete();
        repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 7) begin
        load("1.2.3+");
        target = $urandom_range(MAX_LEN - 4, 140);
        while (text.size() < target) text.push_back(word_char());
      end else begin
        make_version();
        if (kind < 27) mutate();
      end
      steady = ($urandom_range(0, 4) == 0);
      send_text();
    end
    steady = 1'b0;
    drain();
  endtask

  initial begin
    clear_grammar();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_core_numbers();
    test_prerelease();
    test_build_part();
    test_stray_bytes();
    test_extra_core();
    test_length_limit();
    test_back_to_back();
    test_long_hold();
    test_random_versions();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if ((faults == 0) && (verdicts_due.size() == 0)) begin
      $display("semver_string_validator_core verification clean");
    end else begin
      $display("semver_string_validator_core verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/svv_pkg.sv
src/svv_parse.sv
src/semver_string_validator_core.sv
tb/semver_string_validator_core_tb.sv
